/* rtl/ssmh_pkg.sv */
`default_nettype none

package ssmh_pkg;

  // Number of cells in the sorted height chain, and the field widths.
  localparam int SLOTS = 32;
  localparam int HW    = 31;
  localparam int XW    = 31;
  localparam int CW    = 16;

  localparam logic [CW-1:0] CNT_MAX = '1;
  localparam logic [CW-1:0] CNT_ONE = CW'(1);

  // Contents of one cell: a distinct active height and how often it is present.
  typedef struct packed {
    logic          valid;
    logic [HW-1:0] height;
    logic [CW-1:0] count;
  } slot_t;

  // Update operations broadcast to the whole chain.
  localparam logic [2:0] OP_NOP = 3'd0;
  localparam logic [2:0] OP_INC = 3'd1;
  localparam logic [2:0] OP_DEC = 3'd2;
  localparam logic [2:0] OP_INS = 3'd3;
  localparam logic [2:0] OP_DEL = 3'd4;

  // Command bundle from the controller to every cell.
  typedef struct packed {
    logic          clr;
    logic          cmp;
    logic [2:0]    op;
    logic [HW-1:0] height;
  } cell_cmd_t;

  // Controller states.
  localparam logic [1:0] ST_IDLE = 2'd0;
  localparam logic [1:0] ST_CMP  = 2'd1;
  localparam logic [1:0] ST_UPD  = 2'd2;
  localparam logic [1:0] ST_DEC  = 2'd3;

endpackage

`default_nettype wire

/* rtl/ssmh_cell.sv */
`default_nettype none

// One cell of the height chain. The chain is kept sorted with the tallest
// height in cell 0 and all valid cells packed at the low end.
module ssmh_cell (
  input  wire logic              clk,
  input  wire logic              rst_n,
  input  wire ssmh_pkg::cell_cmd_t cmd,
  input  wire ssmh_pkg::slot_t   left_i,
  input  wire logic              left_open_i,
  input  wire ssmh_pkg::slot_t   right_i,
  output ssmh_pkg::slot_t        slot_o,
  output logic                   open_o,
  output logic                   eq_o,
  output logic [ssmh_pkg::CW-1:0] cnt_o
);

  logic                    valid_r, valid_nxt;
  logic [ssmh_pkg::HW-1:0] height_r, height_nxt;
  logic [ssmh_pkg::CW-1:0] count_r, count_nxt;
  logic                    open_r, open_nxt;
  logic                    eq_r, eq_nxt;

  // Compare against the request height, then apply the broadcast update.
  always_comb begin
    valid_nxt  = valid_r;
    height_nxt = height_r;
    count_nxt  = count_r;
    open_nxt   = open_r;
    eq_nxt     = eq_r;
    if (cmd.clr) begin
      valid_nxt = 1'b0;
    end else if (cmd.cmp) begin
      open_nxt = !valid_r || (height_r < cmd.height);
      eq_nxt   = valid_r && (height_r == cmd.height);
    end else begin
      unique case (cmd.op)
        ssmh_pkg::OP_INC: begin
          if (eq_r) count_nxt = count_r + ssmh_pkg::CNT_ONE;
        end
        ssmh_pkg::OP_DEC: begin
          if (eq_r) count_nxt = count_r - ssmh_pkg::CNT_ONE;
        end
        ssmh_pkg::OP_INS: begin
          // Cells at and below the insertion point move one place down.
          if (open_r) begin
            if (left_open_i) begin
              valid_nxt  = left_i.valid;
              height_nxt = left_i.height;
              count_nxt  = left_i.count;
            end else begin
              valid_nxt  = 1'b1;
              height_nxt = cmd.height;
              count_nxt  = ssmh_pkg::CNT_ONE;
            end
          end
        end
        ssmh_pkg::OP_DEL: begin
          // The emptied cell and everything below it move one place up.
          if (eq_r || open_r) begin
            valid_nxt  = right_i.valid;
            height_nxt = right_i.height;
            count_nxt  = right_i.count;
          end
        end
        default: begin
        end
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      valid_r <= 1'b0;
      open_r  <= 1'b0;
      eq_r    <= 1'b0;
    end else begin
      valid_r <= valid_nxt;
      open_r  <= open_nxt;
      eq_r    <= eq_nxt;
    end
    height_r <= height_nxt;
    count_r  <= count_nxt;
  end

  assign slot_o = '{valid: valid_r, height: height_r, count: count_r};
  assign open_o = open_r;
  assign eq_o   = eq_r;
  assign cnt_o  = eq_r ? count_r : '0;

endmodule

`default_nettype wire

/* rtl/skyline_sweep_max_height.sv */
// A request accepted in idle steps through compare, chain update and key-point decision
// states; its key point, if any, is loaded into the output register on leaving the decision
// state, which a key point still held there delays. A new request is taken only once the
// previous one has left the decision state and the sequencer is idle again.
// Reset (rst_n low, synchronous) empties the height chain, clears the output
// history and the sticky overflow flag, and drops any pending key point.
`default_nettype none

module skyline_sweep_max_height (
  input  wire logic        clk,
  input  wire logic        rst_n,
  input  wire logic        in_tvalid,
  output logic             in_tready,
  input  wire logic [63:0] in_tdata,   // edge_x [30:0], edge_height [61:31], zeros [63:62]
  input  wire logic [1:0]  in_tuser,   // start_new [0], is_right [1]
  output logic             out_tvalid,
  input  wire logic        out_tready,
  output logic [63:0]      out_tdata,  // key_x [30:0], key_height [61:31], zeros [63:62]
  output logic             out_tuser   // overflow [0]
);

  localparam int SLOTS = ssmh_pkg::SLOTS;
  localparam int HW    = ssmh_pkg::HW;
  localparam int XW    = ssmh_pkg::XW;
  localparam int CW    = ssmh_pkg::CW;

  logic [1:0]    state_r, state_nxt;
  logic [XW-1:0] ev_x_r;
  logic [HW-1:0] ev_h_r;
  logic          ev_right_r;
  logic          has_given_r, has_given_nxt;
  logic [HW-1:0] last_r, last_nxt;
  logic          ovf_r, ovf_nxt;
  logic          out_valid_r, out_valid_nxt;
  logic [XW-1:0] out_x_r;
  logic [HW-1:0] out_h_r;
  logic          out_ovf_r;

  logic          in_acc;
  logic          out_free;
  logic [2:0]    upd_op;
  logic          upd_ovf;
  logic          found;
  logic          full;
  logic [CW-1:0] match_cnt;
  logic [HW-1:0] cur_max;
  logic          emit;

  ssmh_pkg::cell_cmd_t cmd;
  ssmh_pkg::slot_t     slot_w [SLOTS];
  logic                open_w [SLOTS];
  logic [SLOTS-1:0]    eq_vec;
  logic [SLOTS-1:0]    valid_vec;
  logic [CW-1:0]       cnt_w  [SLOTS];

  assign in_tready = (state_r == ssmh_pkg::ST_IDLE);
  assign in_acc    = in_tvalid && in_tready;
  assign out_free  = !out_valid_r || out_tready;

  // Cell chain: each cell sees its upper and lower neighbor.
  for (genvar i = 0; i < SLOTS; i++) begin : g_cell
    ssmh_pkg::slot_t left_s;
    ssmh_pkg::slot_t right_s;
    logic            left_open;
    if (i == 0) begin : g_first
      assign left_s    = '0;
      assign left_open = 1'b0;
    end else begin : g_mid_l
      assign left_s    = slot_w[i-1];
      assign left_open = open_w[i-1];
    end
    if (i == SLOTS-1) begin : g_last
      assign right_s = '0;
    end else begin : g_mid_r
      assign right_s = slot_w[i+1];
    end
    ssmh_cell u_cell (
      .clk         (clk),
      .rst_n       (rst_n),
      .cmd         (cmd),
      .left_i      (left_s),
      .left_open_i (left_open),
      .right_i     (right_s),
      .slot_o      (slot_w[i]),
      .open_o      (open_w[i]),
      .eq_o        (eq_vec[i]),
      .cnt_o       (cnt_w[i])
    );
    assign valid_vec[i] = slot_w[i].valid;
  end

  // Gather the matching cell's count; at most one cell matches.
  always_comb begin
    match_cnt = '0;
    for (int i = 0; i < SLOTS; i++) begin
      match_cnt = match_cnt | cnt_w[i];
    end
  end

  assign found = |eq_vec;
  assign full  = slot_w[SLOTS-1].valid;

  // Choose the chain update for the current request.
  always_comb begin
    upd_op  = ssmh_pkg::OP_NOP;
    upd_ovf = 1'b0;
    if (!ev_right_r) begin
      if (found) begin
        if (match_cnt == ssmh_pkg::CNT_MAX) upd_ovf = 1'b1;
        else                                upd_op  = ssmh_pkg::OP_INC;
      end else begin
        if (full) upd_ovf = 1'b1;
        else      upd_op  = ssmh_pkg::OP_INS;
      end
    end else begin
      if (found) begin
        if (match_cnt == ssmh_pkg::CNT_ONE) upd_op = ssmh_pkg::OP_DEL;
        else                                upd_op = ssmh_pkg::OP_DEC;
      end else begin
        upd_ovf = 1'b1;
      end
    end
  end

  // Command broadcast to the chain.
  always_comb begin
    cmd.clr    = in_acc && in_tuser[0];
    cmd.cmp    = (state_r == ssmh_pkg::ST_CMP);
    cmd.op     = (state_r == ssmh_pkg::ST_UPD) ? upd_op : ssmh_pkg::OP_NOP;
    cmd.height = ev_h_r;
  end

  // The tallest height sits in cell 0.
  assign cur_max = slot_w[0].valid ? slot_w[0].height : '0;
  assign emit    = !has_given_r || (cur_max != last_r);

  // Sequencer and output history.
  always_comb begin
    state_nxt     = state_r;
    has_given_nxt = has_given_r;
    last_nxt      = last_r;
    ovf_nxt       = ovf_r;
    out_valid_nxt = out_valid_r && !out_tready;
    unique case (state_r)
      ssmh_pkg::ST_IDLE: begin
        if (in_acc) begin
          state_nxt = ssmh_pkg::ST_CMP;
          if (in_tuser[0]) begin
            has_given_nxt = 1'b0;
            last_nxt      = '0;
          end
        end
      end
      ssmh_pkg::ST_CMP: begin
        state_nxt = ssmh_pkg::ST_UPD;
      end
      ssmh_pkg::ST_UPD: begin
        state_nxt = ssmh_pkg::ST_DEC;
        ovf_nxt   = ovf_r || upd_ovf;
      end
      ssmh_pkg::ST_DEC: begin
        if (out_free) begin
          state_nxt = ssmh_pkg::ST_IDLE;
          if (emit) begin
            has_given_nxt = 1'b1;
            last_nxt      = cur_max;
            out_valid_nxt = 1'b1;
          end
        end
      end
      default: begin
        state_nxt = ssmh_pkg::ST_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= ssmh_pkg::ST_IDLE;
      has_given_r <= 1'b0;
      last_r      <= '0;
      ovf_r       <= 1'b0;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      has_given_r <= has_given_nxt;
      last_r      <= last_nxt;
      ovf_r       <= ovf_nxt;
      out_valid_r <= out_valid_nxt;
    end
    if (in_acc) begin
      ev_x_r     <= in_tdata[XW-1:0];
      ev_h_r     <= in_tdata[XW+HW-1:XW];
      ev_right_r <= in_tuser[1];
    end
    if ((state_r == ssmh_pkg::ST_DEC) && out_free && emit) begin
      out_x_r   <= ev_x_r;
      out_h_r   <= cur_max;
      out_ovf_r <= ovf_r;
    end
  end

  assign out_tvalid = out_valid_r;
  assign out_tdata  = {2'b00, out_h_r, out_x_r};
  assign out_tuser  = out_ovf_r;

  // Valid cells form a packed prefix of the chain.
  logic [SLOTS-1:0] valid_inc;
  assign valid_inc = valid_vec + SLOTS'(1);

  a_packed: assert property (@(posedge clk) disable iff (!rst_n)
    (valid_inc & valid_vec) == '0)
    else $error("height chain has a gap");

  a_one_match: assert property (@(posedge clk) disable iff (!rst_n)
    $onehot0(eq_vec))
    else $error("more than one cell matches the request height");

  a_ovf_sticky: assert property (@(posedge clk) disable iff (!rst_n)
    ovf_r |=> ovf_r)
    else $error("overflow flag cleared without reset");

  a_given: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid_r && in_tready) |-> has_given_r)
    else $error("key point pending without output history");

endmodule

`default_nettype wire

/* test/tb_skyline_sweep_max_height.sv */
`timescale 1ns / 100ps

module tb_skyline_sweep_max_height;

  localparam int unsigned LIMIT_CYCLES = 20_000_000;
  localparam int DRAIN_CYCLES = 100;
  localparam int HOLD_AT = 60;
  localparam int HOLD_LEN = 300;
  localparam int RANDOM_WELL_FORMED = 900;
  localparam int RANDOM_TOTAL = 1400;

  // One building edge event as it travels on the input stream.
  typedef struct {
    bit        start;
    bit [30:0] x;
    bit [30:0] h;
    bit        right;
  } edge_ev_t;

  // One skyline key point as it is expected on the output stream.
  typedef struct {
    logic [30:0] x;
    logic [30:0] height;
    logic        ovf;
  } key_pt_t;

  logic        clk = 1'b0;
  logic        rst_n = 1'b0;
  logic        in_tvalid = 1'b0;
  logic        in_tready;
  logic [63:0] in_tdata = '0;   // edge_x [30:0], edge_height [61:31], zeros [63:62]
  logic [1:0]  in_tuser = '0;   // start_new [0], is_right [1]
  logic        out_tvalid;
  logic        out_tready = 1'b0;
  logic [63:0] out_tdata;       // key_x [30:0], key_height [61:31], zeros [63:62]
  logic        out_tuser;       // overflow [0]

  skyline_sweep_max_height dut (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_tvalid (in_tvalid),
    .in_tready (in_tready),
    .in_tdata  (in_tdata),
    .in_tuser  (in_tuser),
    .out_tvalid(out_tvalid),
    .out_tready(out_tready),
    .out_tdata (out_tdata),
    .out_tuser (out_tuser)
  );

  edge_ev_t    edge_queue[$];
  key_pt_t     pending_keys[$];
  logic [31:0] cycle_cnt = '0;
  int          edges_in = 0;
  int          keys_out = 0;
  int          fail_cnt = 0;
  int          gap_left = 0;
  int          stall_left = 0;
  int          hold_left = 0;
  bit          hold_done = 1'b0;
  edge_ev_t    next_ev;
  key_pt_t     got_key;

  // Predicted contents of the height store.
  logic [30:0] store_h[ssmh_pkg::SLOTS];
  logic [15:0] store_n[ssmh_pkg::SLOTS];
  logic [30:0] last_height;
  bit          has_given;
  bit          ovf_flag;

  initial begin
    forever #1 clk = ~clk;
  end

  // Quiet windows: outside the hold-off neither side idles, so back-to-back traffic is seen.
  wire quiet = (cycle_cnt[10:9] == 2'b00);

  // Most gaps are zero or short, a few are long.
  function automatic int pick_gap();
    int r;
    r = $urandom_range(0, 99);
    if (r < 60) return 0;
    if (r < 95) return $urandom_range(1, 3);
    return $urandom_range(8, 30);
  endfunction

  function automatic logic [30:0] pick_height(int mode);
    case (mode)
      0: return 31'($urandom_range(1, 6));
      1: return 31'($urandom_range(1, 32'h7FFF_FFFF));
      default: return 31'h7FFF_FFFF - 31'($urandom_range(0, 3));
    endcase
  endfunction

  function automatic int pick_height_mode();
    int r;
    r = $urandom_range(0, 99);
    if (r < 45) return 0;
    if (r < 85) return 1;
    return 2;
  endfunction

  // Upstream sort order: x ascending, lefts tallest first, then rights shortest first.
  function automatic bit goes_first(edge_ev_t a, edge_ev_t b);
    if (a.x != b.x) return a.x < b.x;
    if (a.right != b.right) return !a.right;
    if (!a.right) return a.h > b.h;
    return a.h < b.h;
  endfunction

  task automatic add_edge(input bit start, input bit [30:0] x, input bit [30:0] h,
                          input bit right);
    edge_ev_t ev;
    ev.start = start;
    ev.x = x;
    ev.h = h;
    ev.right = right;
    edge_queue.insert(edge_queue.size(), ev);
  endtask

  // A sorted frame of buildings; with noisy set, stray edges are mixed in.
  task automatic push_frame(input int n_bldg, input bit noisy);
    edge_ev_t    evs[$];
    edge_ev_t    ev;
    logic [30:0] span;
    logic [30:0] base;
    logic [30:0] a;
    logic [30:0] b;
    logic [30:0] h;
    int          hmode;
    int          j;
    span = $urandom_range(0, 1) ? 31'($urandom_range(0, 24))
                                : 31'($urandom_range(0, 32'h3FFF_FFFF));
    base = 31'($urandom_range(0, 32'h7FFF_FFFF - 32'(span)));
    hmode = pick_height_mode();
    for (int i = 0; i < n_bldg; i++) begin
      a = base + 31'($urandom_range(0, 32'(span)));
      b = base + 31'($urandom_range(0, 32'(span)));
      h = pick_height(hmode);
      ev.start = 1'b0;
      ev.h = h;
      ev.right = 1'b0;
      ev.x = (a < b) ? a : b;
      evs.insert(evs.size(), ev);
      ev.right = 1'b1;
      ev.x = (a < b) ? b : a;
      evs.insert(evs.size(), ev);
    end
    for (int i = 1; i < evs.size(); i++) begin
      ev = evs[i];
      j = i - 1;
      while (j >= 0 && goes_first(ev, evs[j])) begin
        evs[j + 1] = evs[j];
        j--;
      end
      evs[j + 1] = ev;
    end
    if ($urandom_range(0, 4) != 0) evs[0].start = 1'b1;
    foreach (evs[i]) begin
      if (noisy && $urandom_range(0, 6) == 0) begin
        add_edge($urandom_range(0, 15) == 0, 31'($urandom), pick_height(pick_height_mode()),
                 1'($urandom_range(0, 1)));
      end
      edge_queue.insert(edge_queue.size(), evs[i]);
    end
  endtask

  // Applies one accepted edge to the predicted store and queues any key point.
  task automatic track_edge(input bit start, input logic [30:0] x, input logic [30:0] h,
                            input bit right);
    int          hit;
    int          free_idx;
    logic [30:0] top;
    key_pt_t     k;
    hit = -1;
    free_idx = -1;
    top = '0;
    if (start) begin
      foreach (store_n[i]) store_n[i] = '0;
      last_height = '0;
      has_given = 1'b0;
    end
    foreach (store_n[i]) begin
      if (hit < 0 && store_n[i] != 0 && store_h[i] == h) hit = i;
      if (free_idx < 0 && store_n[i] == 0) free_idx = i;
    end
    if (!right) begin
      if (hit >= 0) begin
        if (store_n[hit] == ssmh_pkg::CNT_MAX) ovf_flag = 1'b1;
        else store_n[hit] = store_n[hit] + 16'd1;
      end else if (free_idx < 0) begin
        ovf_flag = 1'b1;
      end else begin
        store_h[free_idx] = h;
        store_n[free_idx] = 16'd1;
      end
    end else begin
      if (hit >= 0) store_n[hit] = store_n[hit] - 16'd1;
      else ovf_flag = 1'b1;
    end
    foreach (store_n[i]) begin
      if (store_n[i] != 0 && store_h[i] > top) top = store_h[i];
    end
    if (!has_given || top != last_height) begin
      has_given = 1'b1;
      last_height = top;
      k.x = x;
      k.height = top;
      k.ovf = ovf_flag;
      pending_keys.insert(pending_keys.size(), k);
    end
  endtask

  // Cycle counter with the run's time limit.
  always @(posedge clk) begin
    cycle_cnt <= cycle_cnt + 32'd1;
    if (cycle_cnt == LIMIT_CYCLES) begin
      $display("timeout after %0d cycles", cycle_cnt);
      $display("end of test: mismatches");
      $finish;
    end
  end

  // Driver: offers queued edges, with random gaps between requests.
  always @(posedge clk) begin
    if (!rst_n) begin
      in_tvalid <= 1'b0;
      gap_left <= 0;
    end else begin
      if (in_tvalid && in_tready) begin
        track_edge(in_tuser[0], in_tdata[30:0], in_tdata[61:31], in_tuser[1]);
        edges_in <= edges_in + 1;
      end
      if (!in_tvalid || in_tready) begin
        if (gap_left != 0 && !quiet) begin
          in_tvalid <= 1'b0;
          gap_left <= gap_left - 1;
        end else if (edge_queue.size() != 0) begin
          next_ev = edge_queue.pop_front();
          in_tvalid <= 1'b1;
          in_tdata <= {2'b00, next_ev.h, next_ev.x};
          in_tuser <= {next_ev.right, next_ev.start};
          gap_left <= pick_gap();
        end else begin
          in_tvalid <= 1'b0;
          gap_left <= 0;
        end
      end
    end
  end

  // One long hold-off on the result side, so that the block backs up.
  always @(posedge clk) begin
    if (!rst_n) begin
      hold_left <= 0;
    end else if (!hold_done && edges_in >= HOLD_AT) begin
      hold_left <= HOLD_LEN;
      hold_done <= 1'b1;
    end else if (hold_left != 0) begin
      hold_left <= hold_left - 1;
    end
  end

  // Monitor: checks each accepted key point and drives a stalling ready.
  always @(posedge clk) begin
    if (!rst_n) begin
      out_tready <= 1'b0;
      stall_left <= 0;
    end else begin
      if (out_tvalid && out_tready) begin
        keys_out <= keys_out + 1;
        if (pending_keys.size() == 0) begin
          $error("key point with none expected: key_x %0d key_height %0d",
                 out_tdata[30:0], out_tdata[61:31]);
          fail_cnt++;
        end else begin
          got_key = pending_keys.pop_front();
          if (out_tdata[30:0] !== got_key.x) begin
            $error("key_x: expected %0d, actual %0d", got_key.x, out_tdata[30:0]);
            fail_cnt++;
          end
          if (out_tdata[61:31] !== got_key.height) begin
            $error("key_height: expected %0d, actual %0d", got_key.height, out_tdata[61:31]);
            fail_cnt++;
          end
          if (out_tuser !== got_key.ovf) begin
            $error("overflow: expected %0d, actual %0d", got_key.ovf, out_tuser);
            fail_cnt++;
          end
        end
      end
      if (hold_left != 0) begin
        out_tready <= 1'b0;
      end else if (quiet) begin
        out_tready <= 1'b1;
        stall_left <= 0;
      end else if (stall_left != 0) begin
        out_tready <= 1'b0;
        stall_left <= stall_left - 1;
      end else if ($urandom_range(0, 99) < 30) begin
        out_tready <= 1'b0;
        stall_left <= pick_gap();
      end else begin
        out_tready <= 1'b1;
      end
    end
  end

  // Stimulus, reset and end of run.
  initial begin
    int base_cnt;
    int n_bldg;
    foreach (store_n[i]) begin
      store_n[i] = '0;
      store_h[i] = '0;
    end
    last_height = '0;
    has_given = 1'b0;
    ovf_flag = 1'b0;

    // Directed: extremes, duplicates, zero height and the start flag.
    add_edge(1'b1, 31'd0, 31'd5, 1'b0);
    add_edge(1'b0, 31'd0, 31'd3, 1'b0);
    add_edge(1'b0, 31'd2, 31'd5, 1'b0);
    add_edge(1'b0, 31'd4, 31'd5, 1'b1);
    add_edge(1'b0, 31'd6, 31'd0, 1'b0);
    add_edge(1'b0, 31'd7, 31'd5, 1'b1);
    add_edge(1'b0, 31'd8, 31'd3, 1'b1);
    add_edge(1'b0, 31'd9, 31'd0, 1'b1);
    add_edge(1'b1, 31'd10, 31'h7FFF_FFFF, 1'b0);
    add_edge(1'b0, 31'd11, 31'h2AAA_AAAA, 1'b0);
    add_edge(1'b0, 31'd12, 31'h5555_5555, 1'b0);
    add_edge(1'b0, 31'd13, 31'h7FFF_FFFF, 1'b1);
    add_edge(1'b0, 31'd14, 31'h5555_5555, 1'b1);
    add_edge(1'b0, 31'h7FFF_FFFF, 31'h2AAA_AAAA, 1'b1);
    // A start with the same height as the last key point still gives one.
    add_edge(1'b1, 31'd20, 31'd1, 1'b0);
    add_edge(1'b1, 31'd21, 31'd1, 1'b0);
    add_edge(1'b0, 31'd22, 31'd1, 1'b1);

    // Random: clean frames first, then frames with table overflow and noise.
    base_cnt = edge_queue.size();
    while (edge_queue.size() - base_cnt < RANDOM_WELL_FORMED) begin
      push_frame($urandom_range(1, 12), 1'b0);
    end
    while (edge_queue.size() - base_cnt < RANDOM_TOTAL) begin
      n_bldg = ($urandom_range(0, 4) == 0) ? $urandom_range(33, 40) : $urandom_range(1, 12);
      push_frame(n_bldg, 1'b1);
    end

    // Removal of an absent height right after a fresh start.
    add_edge(1'b1, 31'd100, 31'd77, 1'b0);
    add_edge(1'b0, 31'd101, 31'd77, 1'b1);
    add_edge(1'b1, 31'd103, 31'd77, 1'b1);
    add_edge(1'b0, 31'd104, 31'd5, 1'b0);

    repeat (8) @(posedge clk);
    rst_n <= 1'b1;

    while (edge_queue.size() != 0 || in_tvalid) @(posedge clk);
    while (pending_keys.size() != 0) @(posedge clk);
    repeat (DRAIN_CYCLES) @(posedge clk);

    $display("run covered %0d edge events and %0d key points in %0d cycles",
             edges_in, keys_out, cycle_cnt);
    $display("predicted overflow flag at the end: %0d", ovf_flag);
    if (fail_cnt == 0) begin
      $display("end of test: clean");
    end else begin
      $display("end of test: mismatches");
    end
    $finish;
  end

endmodule

/* files.f */
rtl/ssmh_pkg.sv
rtl/ssmh_cell.sv
rtl/skyline_sweep_max_height.sv
test/tb_skyline_sweep_max_height.sv
